// File: design/indexed_min_heap_defines.svh
// Assertion macros shared by the indexed min-heap checker.
// No dependencies; included by the checker file.
`ifndef INDEXED_MIN_HEAP_DEFINES_SVH
`define INDEXED_MIN_HEAP_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define IMH_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("indexed_min_heap: assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent
`define IMH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("indexed_min_heap: assertion failed");

`endif

// File: design/imh_pkg.sv
// Package for the indexed min-heap: sizes, codes and transaction structs.
// No dependencies.
`timescale 1ns / 1ps
package imh_pkg;
    localparam int HEAP_DEPTH = 256;
    localparam int ID_SPACE   = 256;
    localparam int SLOT_W     = $clog2(HEAP_DEPTH);
    localparam int ID_W       = $clog2(ID_SPACE);
    localparam int CNT_W      = SLOT_W + 1;
    localparam int CHILD_W    = SLOT_W + 2;
    localparam int KEY_W      = 32;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_REKEY  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BAD_SLOT = 2'd2;

    typedef struct packed {
        logic        [1:0]  operation;
        logic        [7:0]  position;
        logic signed [31:0] key;
        logic        [7:0]  item_id;
    } imh_in_t;

    typedef struct packed {
        logic signed [31:0] min_key;
        logic        [7:0]  min_id;
        logic        [8:0]  entry_total;
        logic        [7:0]  final_slot;
        logic        [1:0]  status;
    } imh_out_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic        [ID_W-1:0]  id;
    } heap_entry_t;

    // heap RAM access from the sequencer
    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        heap_entry_t       wdata;
        logic [SLOT_W-1:0] raddr;
    } heap_port_t;

    // slot table access from the sequencer
    typedef struct packed {
        logic              we;
        logic [ID_W-1:0]   waddr;
        logic [SLOT_W-1:0] wdata;
        logic [ID_W-1:0]   raddr;
    } slot_port_t;
endpackage

// File: design/indexed_min_heap.sv
// Indexed binary min-heap: a transaction is accepted when start is high and
// busy is low. It then walks the heap in one RAM, one level at a time,
// sifting up or down, with setup before and then the final write, slot table
// read-back, root fetch and result. The result shows on result for one cycle
// with done high; the receiver cannot stall it, and busy is already low in
// that cycle.
// Depends on imh_pkg, imh_seq and imh_ram.
`timescale 1ns / 1ps
module indexed_min_heap
    import imh_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  imh_in_t  cmd,
    output logic     busy,
    output logic     done,
    output imh_out_t result
);
    heap_port_t        heap_port;
    heap_entry_t       heap_rdata;
    slot_port_t        slot_port;
    logic [SLOT_W-1:0] slot_rdata;

    // sequencer and compare unit
    imh_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .cmd        (cmd),
        .busy       (busy),
        .done       (done),
        .result     (result),
        .heap_port  (heap_port),
        .heap_rdata (heap_rdata),
        .slot_port  (slot_port),
        .slot_rdata (slot_rdata)
    );

    // heap entries (key, id)
    imh_ram #(
        .WIDTH ($bits(heap_entry_t)),
        .DEPTH (HEAP_DEPTH)
    ) u_heap_ram (
        .clk   (clk),
        .we    (heap_port.we),
        .waddr (heap_port.waddr),
        .wdata (heap_port.wdata),
        .raddr (heap_port.raddr),
        .rdata (heap_rdata)
    );

    // position table indexed by item id
    imh_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (ID_SPACE)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_port.we),
        .waddr (slot_port.waddr),
        .wdata (slot_port.wdata),
        .raddr (slot_port.raddr),
        .rdata (slot_rdata)
    );
endmodule

// File: design/imh_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module imh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: design/imh_seq.sv
// Sequencer and key compare unit of the indexed min-heap: sift up and down.
// Depends on imh_pkg; drives the heap RAM and slot table ports.
`timescale 1ns / 1ps
module imh_seq
    import imh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  imh_in_t     cmd,
    output logic        busy,
    output logic        done,
    output imh_out_t    result,
    output heap_port_t  heap_port,
    input  heap_entry_t heap_rdata,
    output slot_port_t  slot_port,
    input  logic [SLOT_W-1:0] slot_rdata
);
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_RD_LAST = 4'd1;
    localparam logic [3:0] S_RD_POS  = 4'd2;
    localparam logic [3:0] S_UP      = 4'd3;
    localparam logic [3:0] S_UP_CHK  = 4'd4;
    localparam logic [3:0] S_DOWN    = 4'd5;
    localparam logic [3:0] S_DN_L    = 4'd6;
    localparam logic [3:0] S_DN_R    = 4'd7;
    localparam logic [3:0] S_DN_DEC  = 4'd8;
    localparam logic [3:0] S_FINAL   = 4'd9;
    localparam logic [3:0] S_RD_SLOT = 4'd10;
    localparam logic [3:0] S_ROOT    = 4'd11;
    localparam logic [3:0] S_OUT     = 4'd12;

    logic [3:0]              state_reg, state_next;
    logic [CNT_W-1:0]        occ_reg, occ_next;
    logic [SLOT_W-1:0]       i_reg, i_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [ID_W-1:0]         id_reg, id_next;
    logic                    rep_reg, rep_next;
    heap_entry_t             best_reg, best_next;
    logic [SLOT_W-1:0]       bslot_reg, bslot_next;
    logic                    bmv_reg, bmv_next;
    logic [1:0]              status_reg, status_next;
    logic                    use_slot_reg, use_slot_next;
    logic [SLOT_W-1:0]       fslot_reg, fslot_next;
    logic                    done_reg, done_next;
    imh_out_t                result_reg, result_next;

    logic [SLOT_W-1:0]  parent;
    logic [CHILD_W-1:0] left_c, right_c, len_c;
    logic [CNT_W-1:0]   last;

    assign parent  = (i_reg - SLOT_W'(1)) >> 1;
    assign left_c  = {1'b0, i_reg, 1'b1};
    assign right_c = left_c + CHILD_W'(1);
    assign len_c   = CHILD_W'(occ_reg);
    assign last    = occ_reg - CNT_W'(1);

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // next-state and datapath control
    always_comb
    begin
        state_next    = state_reg;
        occ_next      = occ_reg;
        i_next        = i_reg;
        key_next      = key_reg;
        id_next       = id_reg;
        rep_next      = rep_reg;
        best_next     = best_reg;
        bslot_next    = bslot_reg;
        bmv_next      = bmv_reg;
        status_next   = status_reg;
        use_slot_next = use_slot_reg;
        fslot_next    = fslot_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        heap_port     = '0;
        slot_port     = '0;
        slot_port.raddr = id_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                heap_port.raddr = (cmd.operation == OP_DELETE) ? last[SLOT_W-1:0]
                                                               : cmd.position;
                if (start)
                begin
                    status_next   = ST_OK;
                    use_slot_next = 1'b0;
                    fslot_next    = '0;
                    key_next      = cmd.key;
                    id_next       = cmd.item_id;
                    i_next        = cmd.position;
                    rep_next      = 1'b1;
                    priority if (cmd.operation == OP_INSERT)
                    begin
                        if (occ_reg == CNT_W'(HEAP_DEPTH))
                        begin
                            status_next = ST_FULL;
                            state_next  = S_ROOT;
                        end
                        else
                        begin
                            i_next        = occ_reg[SLOT_W-1:0];
                            occ_next      = occ_reg + CNT_W'(1);
                            rep_next      = 1'b0;
                            use_slot_next = 1'b1;
                            state_next    = S_UP;
                        end
                    end
                    else if (cmd.operation == OP_DELETE || cmd.operation == OP_REKEY)
                    begin
                        if (CNT_W'(cmd.position) >= occ_reg)
                        begin
                            status_next = ST_BAD_SLOT;
                            state_next  = S_ROOT;
                        end
                        else if (cmd.operation == OP_DELETE)
                        begin
                            occ_next = last;
                            if (CNT_W'(cmd.position) == last)
                            begin
                                state_next = S_ROOT;
                            end
                            else
                            begin
                                use_slot_next = 1'b1;
                                state_next    = S_RD_LAST;
                            end
                        end
                        else
                        begin
                            use_slot_next = 1'b1;
                            state_next    = S_RD_POS;
                        end
                    end
                    else
                    begin
                        state_next = S_ROOT;
                    end
                end
            end
            S_RD_LAST:
            begin
                key_next   = heap_rdata.key;
                id_next    = heap_rdata.id;
                state_next = S_UP;
            end
            S_RD_POS:
            begin
                id_next    = heap_rdata.id;
                state_next = S_UP;
            end
            // fetch parent, or at the root leave sift up
            S_UP:
            begin
                heap_port.raddr = parent;
                if (i_reg == '0)
                begin
                    state_next = rep_reg ? S_DOWN : S_FINAL;
                end
                else
                begin
                    state_next = S_UP_CHK;
                end
            end
            // parent larger: pull it down one level
            S_UP_CHK:
            begin
                if (heap_rdata.key > key_reg)
                begin
                    heap_port.we    = 1'b1;
                    heap_port.waddr = i_reg;
                    heap_port.wdata = heap_rdata;
                    slot_port.we    = 1'b1;
                    slot_port.waddr = heap_rdata.id;
                    slot_port.wdata = i_reg;
                    i_next          = parent;
                    rep_next        = 1'b0;
                    state_next      = S_UP;
                end
                else
                begin
                    state_next = rep_reg ? S_DOWN : S_FINAL;
                end
            end
            S_DOWN:
            begin
                heap_port.raddr = left_c[SLOT_W-1:0];
                state_next      = (left_c < len_c) ? S_DN_L : S_FINAL;
            end
            // left child against moving key
            S_DN_L:
            begin
                heap_port.raddr = right_c[SLOT_W-1:0];
                if (heap_rdata.key < key_reg)
                begin
                    best_next  = heap_rdata;
                    bslot_next = left_c[SLOT_W-1:0];
                    bmv_next   = 1'b1;
                end
                else
                begin
                    best_next.key = key_reg;
                    best_next.id  = id_reg;
                    bmv_next      = 1'b0;
                end
                state_next = (right_c < len_c) ? S_DN_R : S_DN_DEC;
            end
            // right child against the best so far
            S_DN_R:
            begin
                if (heap_rdata.key < best_reg.key)
                begin
                    best_next  = heap_rdata;
                    bslot_next = right_c[SLOT_W-1:0];
                    bmv_next   = 1'b1;
                end
                state_next = S_DN_DEC;
            end
            S_DN_DEC:
            begin
                if (bmv_reg)
                begin
                    heap_port.we    = 1'b1;
                    heap_port.waddr = i_reg;
                    heap_port.wdata = best_reg;
                    slot_port.we    = 1'b1;
                    slot_port.waddr = best_reg.id;
                    slot_port.wdata = i_reg;
                    i_next          = bslot_reg;
                    state_next      = S_DOWN;
                end
                else
                begin
                    state_next = S_FINAL;
                end
            end
            // place the moving entry
            S_FINAL:
            begin
                heap_port.we        = 1'b1;
                heap_port.waddr     = i_reg;
                heap_port.wdata.key = key_reg;
                heap_port.wdata.id  = id_reg;
                slot_port.we        = 1'b1;
                slot_port.waddr     = id_reg;
                slot_port.wdata     = i_reg;
                state_next          = S_RD_SLOT;
            end
            S_RD_SLOT:
            begin
                state_next = S_ROOT;
            end
            // capture final slot from the table, fetch root
            S_ROOT:
            begin
                heap_port.raddr = '0;
                if (use_slot_reg)
                begin
                    fslot_next = slot_rdata;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (occ_reg != '0)
                begin
                    result_next.min_key = heap_rdata.key;
                    result_next.min_id  = heap_rdata.id;
                end
                else
                begin
                    result_next.min_key = '0;
                    result_next.min_id  = '0;
                end
                result_next.entry_total = occ_reg;
                result_next.final_slot  = fslot_reg;
                result_next.status      = status_reg;
                done_next               = 1'b1;
                state_next              = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            occ_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        i_reg        <= i_next;
        key_reg      <= key_next;
        id_reg       <= id_next;
        rep_reg      <= rep_next;
        best_reg     <= best_next;
        bslot_reg    <= bslot_next;
        bmv_reg      <= bmv_next;
        status_reg   <= status_next;
        use_slot_reg <= use_slot_next;
        fslot_reg    <= fslot_next;
        result_reg   <= result_next;
    end
endmodule

// File: design/imh_checker.sv
// Port-level checker for the indexed min-heap, bound to the top level.
// Depends on imh_pkg and indexed_min_heap_defines.svh.
`timescale 1ns / 1ps
`include "indexed_min_heap_defines.svh"
module imh_checker
    import imh_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input logic     done,
    input imh_out_t result
);
    `IMH_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done)
    `IMH_ASSERT_IMP(a_done_after_busy, done, !busy && $past(busy))
    `IMH_ASSERT_IMP(a_empty_root, done && result.entry_total == 9'd0,
        result.min_key == 32'sd0 && result.min_id == 8'd0)
    `IMH_ASSERT_IMP(a_full_reject, done && result.status == ST_FULL,
        result.entry_total == 9'd256 && result.final_slot == 8'd0)
endmodule

bind indexed_min_heap imh_checker u_imh_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// File: tb/sv/indexed_min_heap_tb.sv
// Self-checking testbench for the indexed min-heap: drives insert, delete and
// rekey transactions, predicts each result with a behavioral heap, compares.
// Depends on imh_pkg and the indexed_min_heap RTL.
`timescale 1ns / 1ps
module indexed_min_heap_tb;
    import imh_pkg::*;

    // operation code with no function
    localparam logic [1:0] OP_IGNORED = 2'd3;

    logic     clk;
    logic     rst_n;
    logic     start;
    imh_in_t  cmd;
    logic     busy;
    logic     done;
    imh_out_t result;

    indexed_min_heap dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    // Behavioral heap copy
    logic signed [31:0] hp_key [HEAP_DEPTH];
    logic [7:0]         hp_id  [HEAP_DEPTH];
    logic [7:0]         id_slot [ID_SPACE];
    int unsigned        hp_count;

    imh_out_t    expected_q [$];
    int          error_count;
    int          send_gap_pct;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
    begin
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        error_count++;
    end
    endtask

    function automatic void place(input int unsigned s, input logic signed [31:0] k,
                                  input logic [7:0] id);
    begin
        hp_key[s] = k;
        hp_id[s]  = id;
        id_slot[id] = s[7:0];
    end
    endfunction

    function automatic int unsigned bubble_up(input int unsigned i);
        logic signed [31:0] k;
        logic [7:0]         id;
        int unsigned        p;
    begin
        k  = hp_key[i];
        id = hp_id[i];
        while (i > 0)
        begin
            p = (i - 1) >> 1;
            if (!(hp_key[p] > k))
                break;
            place(i, hp_key[p], hp_id[p]);
            i = p;
        end
        place(i, k, id);
        return i;
    end
    endfunction

    function automatic int unsigned bubble_down(input int unsigned i);
        logic signed [31:0] k;
        logic signed [31:0] bk;
        logic [7:0]         id;
        int unsigned        best;
    begin
        k  = hp_key[i];
        id = hp_id[i];
        forever
        begin
            best = i;
            bk   = k;
            if (2 * i + 1 < hp_count && hp_key[2 * i + 1] < bk)
            begin
                best = 2 * i + 1;
                bk   = hp_key[best];
            end
            if (2 * i + 2 < hp_count && hp_key[2 * i + 2] < bk)
                best = 2 * i + 2;
            if (best == i)
                break;
            place(i, hp_key[best], hp_id[best]);
            i = best;
        end
        place(i, k, id);
        return i;
    end
    endfunction

    function automatic int unsigned restore_order(input int unsigned i);
    begin
        if (i > 0 && hp_key[(i - 1) >> 1] > hp_key[i])
            return bubble_up(i);
        return bubble_down(i);
    end
    endfunction

    // Predict the result of one transaction and update the heap copy
    function automatic imh_out_t predict_heap_op(input imh_in_t c);
        imh_out_t    r;
        int unsigned last;
        int unsigned fs;
    begin
        r  = '0;
        fs = 0;
        if (c.operation == OP_INSERT)
        begin
            if (hp_count >= HEAP_DEPTH)
                r.status = ST_FULL;
            else
            begin
                place(hp_count, c.key, c.item_id);
                fs = bubble_up(hp_count);
                hp_count++;
            end
        end
        else if (c.operation == OP_DELETE || c.operation == OP_REKEY)
        begin
            if (32'(c.position) >= hp_count)
                r.status = ST_BAD_SLOT;
            else if (c.operation == OP_DELETE)
            begin
                last = hp_count - 1;
                hp_count = last;
                if (32'(c.position) < last)
                begin
                    place(32'(c.position), hp_key[last], hp_id[last]);
                    fs = restore_order(32'(c.position));
                end
            end
            else
            begin
                hp_key[c.position] = c.key;
                fs = restore_order(32'(c.position));
            end
        end
        if (hp_count > 0)
        begin
            r.min_key = hp_key[0];
            r.min_id  = hp_id[0];
        end
        r.final_slot  = fs[7:0];
        r.entry_total = hp_count[8:0];
        return r;
    end
    endfunction

    // Send one transaction, with a random idle gap first
    task automatic send_cmd(input imh_in_t c);
        int idle;
    begin
        idle = 0;
        while ($urandom_range(99) < send_gap_pct)
            idle++;
        if (idle > 0)
        begin
            start <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_q.push_back(predict_heap_op(c));
    end
    endtask

    task automatic send_op(input logic [1:0] op, input int pos, input logic [31:0] k,
                           input int id);
        imh_in_t c;
    begin
        c.operation = op;
        c.position  = pos[7:0];
        c.key       = k;
        c.item_id   = id[7:0];
        send_cmd(c);
    end
    endtask

    task automatic wait_drained();
    begin
        start <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        imh_out_t want;
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected result", 32'd1, 32'd0);
            end
            else
            begin
                want = expected_q.pop_front();
                if (result.min_key !== want.min_key)
                    report_mismatch("min_key", result.min_key, want.min_key);
                if (result.min_id !== want.min_id)
                    report_mismatch("min_id", 32'(result.min_id), 32'(want.min_id));
                if (result.entry_total !== want.entry_total)
                    report_mismatch("entry_total", 32'(result.entry_total),
                                    32'(want.entry_total));
                if (result.final_slot !== want.final_slot)
                    report_mismatch("final_slot", 32'(result.final_slot),
                                    32'(want.final_slot));
                if (result.status !== want.status)
                    report_mismatch("status", 32'(result.status), 32'(want.status));
            end
        end
    end

    // Field extremes, every operation, empty and bad-slot cases
    task automatic test_directed();
    begin
        send_op(OP_DELETE, 0, 0, 0);
        send_op(OP_REKEY, 0, 5, 0);
        send_op(OP_IGNORED, 255, 32'hFFFF_FFFF, 255);
        send_op(OP_INSERT, 0, 32'h7FFF_FFFF, 255);
        send_op(OP_INSERT, 255, 32'h8000_0000, 0);
        send_op(OP_INSERT, 0, 0, 255);
        send_op(OP_INSERT, 0, 32'hFFFF_FFFF, 170);
        send_op(OP_INSERT, 0, 0, 85);
        send_op(OP_REKEY, 3, 32'h8000_0000, 1);
        send_op(OP_REKEY, 0, 32'h7FFF_FFFF, 2);
        send_op(OP_DELETE, 4, 0, 0);
        send_op(OP_DELETE, 0, 0, 0);
        send_op(OP_DELETE, 255, 0, 0);
        send_op(OP_REKEY, 200, 0, 0);
        send_op(OP_IGNORED, 0, 0, 0);
        send_op(OP_DELETE, 0, 0, 0);
        send_op(OP_DELETE, 0, 0, 0);
        send_op(OP_DELETE, 0, 0, 0);
        send_op(OP_DELETE, 0, 0, 0);
    end
    endtask

    // Fill to capacity, insert on full, then drain
    task automatic test_full_heap();
    begin
        while (hp_count < HEAP_DEPTH)
            send_op(OP_INSERT, $urandom, $urandom_range(1000), $urandom);
        send_op(OP_INSERT, 0, 1, 7);
        send_op(OP_DELETE, 255, 0, 0);
        send_op(OP_INSERT, 0, 32'h8000_0000, 9);
        send_op(OP_INSERT, 0, 3, 9);
        send_op(OP_REKEY, 255, 32'h7FFF_FFFF, 0);
        wait_drained();
        while (hp_count > 0)
            send_op(OP_DELETE, $urandom_range(hp_count - 1), 0, 0);
    end
    endtask

    // Random mix, mostly valid positions
    task automatic test_random(input int n);
        int          i;
        int unsigned sel;
        logic [31:0] k;
        int          pos;
    begin
        for (i = 0; i < n; i++)
        begin
            sel = $urandom_range(99);
            k = ($urandom_range(1)) ? $urandom : $urandom_range(20);
            if (hp_count > 0 && $urandom_range(9) != 0)
                pos = $urandom_range(hp_count - 1);
            else
                pos = $urandom_range(255);
            if (sel < 45)
                send_op(OP_INSERT, $urandom, k, $urandom);
            else if (sel < 75)
                send_op(OP_DELETE, pos, $urandom, $urandom);
            else if (sel < 97)
                send_op(OP_REKEY, pos, k, $urandom);
            else
                send_op(OP_IGNORED, $urandom, $urandom, $urandom);
        end
    end
    endtask

    initial
    begin
        error_count  = 0;
        hp_count     = 0;
        send_gap_pct = 14;
        rst_n = 1'b0;
        start = 1'b0;
        cmd   = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(250);
        wait_drained();
        send_gap_pct = 51;
        test_full_heap();
        test_random(250);
        wait_drained();
        send_gap_pct = 0;
        test_random(250);
        wait_drained();
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+design
design/imh_pkg.sv
design/imh_ram.sv
design/imh_seq.sv
design/indexed_min_heap.sv
design/imh_checker.sv
tb/sv/indexed_min_heap_tb.sv
